### hw/rtl/c8alu_pkg.sv
// Shared types and constants for the CHIP-8 register and ALU execute unit.
`timescale 1ns / 1ps

package c8alu_pkg;

   // Register file geometry
   localparam int NUM_REGS   = 16;
   localparam int REG_AW     = 4;
   localparam logic [REG_AW-1:0] VF_INDEX = 4'hF;

   // Font sprites start here in memory
   localparam logic [15:0] FONT_BASE = 16'h0050;

   // Item commands
   localparam logic [1:0] CMD_EXEC  = 2'd0;
   localparam logic [1:0] CMD_DELAY = 2'd1;
   localparam logic [1:0] CMD_SOUND = 2'd2;

   // Opcode nibbles
   localparam logic [3:0] OP_SE_IMM  = 4'h3;
   localparam logic [3:0] OP_SNE_IMM = 4'h4;
   localparam logic [3:0] OP_SE_REG  = 4'h5;
   localparam logic [3:0] OP_LD_IMM  = 4'h6;
   localparam logic [3:0] OP_ADD_IMM = 4'h7;
   localparam logic [3:0] OP_ALU     = 4'h8;
   localparam logic [3:0] OP_SNE_REG = 4'h9;
   localparam logic [3:0] OP_LD_I    = 4'hA;
   localparam logic [3:0] OP_RND     = 4'hC;
   localparam logic [3:0] OP_MISC    = 4'hF;

   // ALU forms of 8xyN
   localparam logic [3:0] ALU_MOV = 4'h0;
   localparam logic [3:0] ALU_OR  = 4'h1;
   localparam logic [3:0] ALU_AND = 4'h2;
   localparam logic [3:0] ALU_XOR = 4'h3;
   localparam logic [3:0] ALU_ADD = 4'h4;
   localparam logic [3:0] ALU_SUB = 4'h5;
   localparam logic [3:0] ALU_SHR = 4'h6;
   localparam logic [3:0] ALU_SBN = 4'h7;
   localparam logic [3:0] ALU_SHL = 4'hE;

   // Low bytes of Fxkk
   localparam logic [7:0] MISC_GET_DT = 8'h07;
   localparam logic [7:0] MISC_SET_DT = 8'h15;
   localparam logic [7:0] MISC_SET_ST = 8'h18;
   localparam logic [7:0] MISC_ADD_I  = 8'h1E;
   localparam logic [7:0] MISC_FONT   = 8'h29;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] instr_word;
      logic [7:0]  rand_byte;
   } req_payload_type;

   typedef struct packed {
      logic        handled;
      logic        skip_next;
      logic [7:0]  vx_result;
      logic [7:0]  flag_vf;
      logic [15:0] index_value;
      logic [7:0]  delay_value;
      logic [7:0]  sound_value;
      logic        sound_on;
   } rsp_payload_type;

   // Register file write request, x = 15 already folded into the VF write
   typedef struct packed {
      logic              arr_we;
      logic [REG_AW-1:0] arr_addr;
      logic [7:0]        arr_data;
      logic              vf_we;
      logic [7:0]        vf_data;
   } rf_wr_type;

   // Index and timer values
   typedef struct packed {
      logic [15:0] index_reg;
      logic [7:0]  delay_timer;
      logic [7:0]  sound_timer;
   } ctl_state_type;

endpackage

### hw/rtl/c8alu_if.sv
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps

interface c8alu_req_if
   import c8alu_pkg::*;
();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface c8alu_rsp_if
   import c8alu_pkg::*;
();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/c8alu_regfile.sv
// V register file: 15-entry array plus a separate VF register, two registered read ports.
`timescale 1ns / 1ps

module c8alu_regfile
   import c8alu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [REG_AW-1:0] rd_addr_a,
   input  logic [REG_AW-1:0] rd_addr_b,
   input  rf_wr_type         wr,
   output logic [7:0]        rd_data_a,
   output logic [7:0]        rd_data_b,
   output logic [7:0]        vf_value
);

   logic [7:0]          vreg_mem_ff [NUM_REGS-1];
   logic [NUM_REGS-2:0] valid_ff;
   logic [NUM_REGS-2:0] valid_in;
   logic [7:0]          vf_ff;
   logic [7:0]          vf_in;
   logic [7:0]          rd_a_ff;
   logic [7:0]          rd_b_ff;

   // Next VF value, forwarded to readers of address 15
   always_comb begin
      vf_in = wr.vf_we ? wr.vf_data : vf_ff;
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr.arr_we) begin
         valid_in[wr.arr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vf_ff    <= '0;
         valid_ff <= '0;
      end else begin
         vf_ff    <= vf_in;
         valid_ff <= valid_in;
      end
   end

   // Write the array; entries never written read as zero
   always_ff @(posedge clock) begin
      if (wr.arr_we) begin
         vreg_mem_ff[wr.arr_addr] <= wr.arr_data;
      end
   end

   // Read both ports, write-first against a write at the same edge
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (rd_addr_a == VF_INDEX) begin
            rd_a_ff <= vf_in;
         end else if (wr.arr_we && wr.arr_addr == rd_addr_a) begin
            rd_a_ff <= wr.arr_data;
         end else if (valid_ff[rd_addr_a]) begin
            rd_a_ff <= vreg_mem_ff[rd_addr_a];
         end else begin
            rd_a_ff <= '0;
         end

         if (rd_addr_b == VF_INDEX) begin
            rd_b_ff <= vf_in;
         end else if (wr.arr_we && wr.arr_addr == rd_addr_b) begin
            rd_b_ff <= wr.arr_data;
         end else if (valid_ff[rd_addr_b]) begin
            rd_b_ff <= vreg_mem_ff[rd_addr_b];
         end else begin
            rd_b_ff <= '0;
         end
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
   assign vf_value  = vf_ff;

endmodule

### hw/rtl/c8alu_exec.sv
// Decode and execute of one item: ALU, skip compare, index and timer updates.
`timescale 1ns / 1ps

module c8alu_exec
   import c8alu_pkg::*;
(
   input  req_payload_type item,
   input  logic [7:0]      vx,
   input  logic [7:0]      vy,
   input  logic [7:0]      vf,
   input  ctl_state_type   state,
   output rf_wr_type       wr,
   output ctl_state_type   state_next,
   output rsp_payload_type result
);

   logic [3:0]  op;
   logic [3:0]  x;
   logic [3:0]  n;
   logic [7:0]  kk;
   logic [11:0] nnn;
   logic [8:0]  sum9;
   logic        handled;
   logic        skip;
   logic        wv_en;
   logic [7:0]  wv;
   logic        flag_en;
   logic        flag;
   logic [7:0]  vf_after;
   logic [7:0]  vx_after;

   assign op   = item.instr_word[15:12];
   assign x    = item.instr_word[11:8];
   assign n    = item.instr_word[3:0];
   assign kk   = item.instr_word[7:0];
   assign nnn  = item.instr_word[11:0];
   assign sum9 = {1'b0, vx} + {1'b0, vy};

   // Decode and compute the write-back
   always_comb begin
      handled    = 1'b0;
      skip       = 1'b0;
      wv_en      = 1'b0;
      wv         = '0;
      flag_en    = 1'b0;
      flag       = 1'b0;
      state_next = state;
      unique case (item.cmd)
         CMD_EXEC: begin
            unique case (op)
               OP_SE_IMM: begin
                  handled = 1'b1;
                  skip    = (vx == kk);
               end
               OP_SNE_IMM: begin
                  handled = 1'b1;
                  skip    = (vx != kk);
               end
               OP_SE_REG: begin
                  handled = (n == 4'h0);
                  skip    = (n == 4'h0) && (vx == vy);
               end
               OP_SNE_REG: begin
                  handled = (n == 4'h0);
                  skip    = (n == 4'h0) && (vx != vy);
               end
               OP_LD_IMM: begin
                  handled = 1'b1;
                  wv_en   = 1'b1;
                  wv      = kk;
               end
               OP_ADD_IMM: begin
                  handled = 1'b1;
                  wv_en   = 1'b1;
                  wv      = vx + kk;
               end
               OP_ALU: begin
                  unique case (n)
                     ALU_MOV: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = vy;
                     end
                     ALU_OR: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = vx | vy;
                     end
                     ALU_AND: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = vx & vy;
                     end
                     ALU_XOR: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = vx ^ vy;
                     end
                     ALU_ADD: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = sum9[7:0];
                        flag_en = 1'b1;
                        flag    = sum9[8];
                     end
                     ALU_SUB: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = vx - vy;
                        flag_en = 1'b1;
                        flag    = (vx >= vy);
                     end
                     ALU_SHR: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = {1'b0, vx[7:1]};
                        flag_en = 1'b1;
                        flag    = vx[0];
                     end
                     ALU_SBN: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = vy - vx;
                        flag_en = 1'b1;
                        flag    = (vy >= vx);
                     end
                     ALU_SHL: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = {vx[6:0], 1'b0};
                        flag_en = 1'b1;
                        flag    = vx[7];
                     end
                     default: begin
                        handled = 1'b0;
                     end
                  endcase
               end
               OP_LD_I: begin
                  handled              = 1'b1;
                  state_next.index_reg = {4'h0, nnn};
               end
               OP_RND: begin
                  handled = 1'b1;
                  wv_en   = 1'b1;
                  wv      = item.rand_byte & kk;
               end
               OP_MISC: begin
                  unique case (kk)
                     MISC_GET_DT: begin
                        handled = 1'b1;
                        wv_en   = 1'b1;
                        wv      = state.delay_timer;
                     end
                     MISC_SET_DT: begin
                        handled                = 1'b1;
                        state_next.delay_timer = vx;
                     end
                     MISC_SET_ST: begin
                        handled                = 1'b1;
                        state_next.sound_timer = vx;
                     end
                     MISC_ADD_I: begin
                        handled              = 1'b1;
                        state_next.index_reg = state.index_reg + {8'h00, vx};
                     end
                     MISC_FONT: begin
                        // font sprite address: base plus five times the digit
                        handled              = 1'b1;
                        state_next.index_reg = FONT_BASE + {10'h000, vx[3:0], 2'b00}
                                               + {12'h000, vx[3:0]};
                     end
                     default: begin
                        handled = 1'b0;
                     end
                  endcase
               end
               default: begin
                  handled = 1'b0;
               end
            endcase
         end
         CMD_DELAY: begin
            handled = 1'b1;
            if (state.delay_timer != 8'h00) begin
               state_next.delay_timer = state.delay_timer - 8'h01;
            end
         end
         CMD_SOUND: begin
            handled = 1'b1;
            if (state.sound_timer != 8'h00) begin
               state_next.sound_timer = state.sound_timer - 8'h01;
            end
         end
         default: begin
            handled = 1'b0;
         end
      endcase
   end

   // Fold writes to V15: the flag lands after the result
   always_comb begin
      if (flag_en) begin
         vf_after = {7'h00, flag};
      end else if (wv_en && x == VF_INDEX) begin
         vf_after = wv;
      end else begin
         vf_after = vf;
      end

      if (x == VF_INDEX) begin
         vx_after = vf_after;
      end else if (wv_en) begin
         vx_after = wv;
      end else begin
         vx_after = vx;
      end

      wr.arr_we   = wv_en && (x != VF_INDEX);
      wr.arr_addr = x;
      wr.arr_data = wv;
      wr.vf_we    = flag_en || (wv_en && x == VF_INDEX);
      wr.vf_data  = vf_after;
   end

   // Assemble the response item
   always_comb begin
      result.handled     = handled;
      result.skip_next   = skip;
      result.vx_result   = vx_after;
      result.flag_vf     = vf_after;
      result.index_value = state_next.index_reg;
      result.delay_value = state_next.delay_timer;
      result.sound_value = state_next.sound_timer;
      result.sound_on    = (state_next.sound_timer != 8'h00);
   end

endmodule

### hw/rtl/chip8_register_alu_unit.sv
// Top level of the CHIP-8 register and ALU execute unit.
//
//   channel  direction  handshake            payload
//   req_ch   in         valid/ready          cmd, instr_word, rand_byte
//   rsp_ch   out        valid/ready          handled, skip_next, vx_result, flag_vf,
//                                            index_value, delay_value, sound_value, sound_on
//
// One item per cycle sustained while rsp_ch is ready; a taken request passes the input register
// (register read at accept), then execute and write-back into the response register.
// State updates land at the same edge the response is registered, so the next item
// sees them through the register file's write-first read.
// Reset is synchronous and clears V registers (per-entry valid bits), I and both timers.
// A stalled response holds the input register; one request can wait behind it.
`timescale 1ns / 1ps

module chip8_register_alu_unit
   import c8alu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   c8alu_req_if.sink          req_ch,
   c8alu_rsp_if.source        rsp_ch
);

   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_item_ff;
   ctl_state_type   ctl_ff;
   ctl_state_type   ctl_in;
   ctl_state_type   ctl_next;
   rsp_payload_type exec_result;
   rf_wr_type       exec_wr;
   rf_wr_type       rf_wr;
   logic            accept;
   logic            advance;
   logic [7:0]      vx;
   logic [7:0]      vy;
   logic [7:0]      vf;

   // Handshake control
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !reset && (!in_valid_ff || advance);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      ctl_in = advance ? ctl_next : ctl_ff;

      rf_wr        = exec_wr;
      rf_wr.arr_we = exec_wr.arr_we && advance;
      rf_wr.vf_we  = exec_wr.vf_we && advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctl_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctl_ff       <= ctl_in;
      end
   end

   // Capture the request and register the result
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_ch.payload;
      end
      if (advance) begin
         out_item_ff <= exec_result;
      end
   end

   c8alu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr_a (req_ch.payload.instr_word[11:8]),
      .rd_addr_b (req_ch.payload.instr_word[7:4]),
      .wr        (rf_wr),
      .rd_data_a (vx),
      .rd_data_b (vy),
      .vf_value  (vf)
   );

   c8alu_exec u_exec (
      .item       (in_item_ff),
      .vx         (vx),
      .vy         (vy),
      .vf         (vf),
      .state      (ctl_ff),
      .wr         (exec_wr),
      .state_next (ctl_next),
      .result     (exec_result)
   );

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_item_ff;

endmodule
